// ===== hw/rtl/nit_pkg.sv =====
// shared constants and types for the nested interval timer
`timescale 1ns / 1ps

package nit_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int TIME_W      = 48;
   localparam int ID_W        = 16;
   localparam int DEPTH_W     = 4;
   localparam int ENTRY_W     = ID_W + TIME_W;

   localparam logic KIND_BEGIN = 1'b0;
   localparam logic KIND_END   = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_UNDERFLOW = 2'd1,
      STATUS_OVERFLOW  = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_POP  = 1'b1
   } state_type;

endpackage

// ===== hw/rtl/nested_interval_timer.sv =====
// nested interval timer top level: stack of open regions in a synchronous memory
`timescale 1ns / 1ps

// Each item is a begin or an end carrying a region id and a 48-bit timestamp.
// A begin pushes id and start time onto a stack memory of nit_pkg::STACK_DEPTH
// entries and gives no result; an end pops the innermost region and gives one
// record with id, nesting depth (modulo 16), start time and duration modulo
// 2^48. An end on an empty stack gives an underflow status, a begin on a full
// stack an overflow status; both leave the stack as it was. With the enable
// register low every item is taken and dropped. Begins and errors can follow
// back to back; a successful end passes through the ST_POP state, because the
// stack memory read is registered before the record can be formed, and the
// input is stalled in ST_POP. The result register lets the next item in while
// the previous result is being taken; an item also waits while an unconsumed
// result is stalled. There is no clearing pass: the count alone says what is
// valid.
module nested_interval_timer (
   input  logic                         clock,
   input  logic                         reset,
   // input channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_kind,
   input  logic [nit_pkg::ID_W-1:0]     req_region_id,
   input  logic [nit_pkg::TIME_W-1:0]   req_time_us,
   // result channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_status,
   output logic [nit_pkg::ID_W-1:0]     rsp_region_out,
   output logic [nit_pkg::DEPTH_W-1:0]  rsp_depth,
   output logic [nit_pkg::TIME_W-1:0]   rsp_start_us,
   output logic [nit_pkg::TIME_W-1:0]   rsp_duration_us,
   // configuration
   input  logic                         csr_we,
   input  logic                         csr_wdata
);

   // stack memory: id in the upper bits, start time in the lower bits
   logic [nit_pkg::ENTRY_W-1:0] stack_mem [nit_pkg::STACK_DEPTH];
   logic [nit_pkg::ENTRY_W-1:0] rd_data_ff;

   nit_pkg::state_type          state_ff, state_in;
   logic [nit_pkg::CNT_W-1:0]   count_ff, count_in;
   logic                        enable_ff;
   logic [nit_pkg::TIME_W-1:0]  end_time_ff;

   // result register
   logic                        rsp_valid_ff;
   nit_pkg::status_type         status_ff;
   logic [nit_pkg::ID_W-1:0]    region_ff;
   logic [nit_pkg::DEPTH_W-1:0] depth_ff;
   logic [nit_pkg::TIME_W-1:0]  start_ff;
   logic [nit_pkg::TIME_W-1:0]  dur_ff;

   logic                        accept;
   logic                        full;
   logic                        empty;
   logic                        push_en;
   logic                        pop_en;
   logic                        err_en;
   nit_pkg::status_type         err_code;
   logic [nit_pkg::IDX_W-1:0]   push_idx;
   logic [nit_pkg::IDX_W-1:0]   pop_idx;
   logic [nit_pkg::CNT_W-1:0]   count_dec;

   // take an item only when no pop is in flight and the result slot drains
   assign req_stall = (state_ff != nit_pkg::ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   assign full      = (count_ff == nit_pkg::CNT_W'(nit_pkg::STACK_DEPTH));
   assign empty     = (count_ff == '0);
   assign count_dec = count_ff - nit_pkg::CNT_W'(1);
   assign push_idx  = count_ff[nit_pkg::IDX_W-1:0];
   assign pop_idx   = count_dec[nit_pkg::IDX_W-1:0];

   // item decode
   always_comb begin
      push_en  = 1'b0;
      pop_en   = 1'b0;
      err_en   = 1'b0;
      err_code = nit_pkg::STATUS_OK;
      if (accept && enable_ff) begin
         if (req_kind == nit_pkg::KIND_BEGIN) begin
            if (full) begin
               err_en   = 1'b1;
               err_code = nit_pkg::STATUS_OVERFLOW;
            end else begin
               push_en  = 1'b1;
            end
         end else begin
            if (empty) begin
               err_en   = 1'b1;
               err_code = nit_pkg::STATUS_UNDERFLOW;
            end else begin
               pop_en   = 1'b1;
            end
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         nit_pkg::ST_IDLE: begin
            if (pop_en) state_in = nit_pkg::ST_POP;
         end
         nit_pkg::ST_POP: begin
            state_in = nit_pkg::ST_IDLE;
         end
         default: begin
            state_in = nit_pkg::ST_IDLE;
         end
      endcase
   end

   // count update
   always_comb begin
      count_in = count_ff;
      if (push_en) begin
         count_in = count_ff + nit_pkg::CNT_W'(1);
      end else if (pop_en) begin
         count_in = count_dec;
      end
   end

   // stack memory: write on push, registered read on pop
   always_ff @(posedge clock) begin
      if (push_en) begin
         stack_mem[push_idx] <= {req_region_id, req_time_us};
      end
      if (pop_en) begin
         rd_data_ff <= stack_mem[pop_idx];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= nit_pkg::ST_IDLE;
         count_ff  <= '0;
         enable_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         if (csr_we) enable_ff <= csr_wdata;
      end
   end

   // end time travels with the pop
   always_ff @(posedge clock) begin
      if (pop_en) end_time_ff <= req_time_us;
   end

   // result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (err_en || (state_ff == nit_pkg::ST_POP)) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result payload: error codes load at once, records after the memory read
   always_ff @(posedge clock) begin
      if (err_en) begin
         status_ff <= err_code;
         region_ff <= '0;
         depth_ff  <= '0;
         start_ff  <= '0;
         dur_ff    <= '0;
      end else if (state_ff == nit_pkg::ST_POP) begin
         status_ff <= nit_pkg::STATUS_OK;
         region_ff <= rd_data_ff[nit_pkg::ENTRY_W-1:nit_pkg::TIME_W];
         depth_ff  <= nit_pkg::DEPTH_W'(count_ff);
         start_ff  <= rd_data_ff[nit_pkg::TIME_W-1:0];
         dur_ff    <= end_time_ff - rd_data_ff[nit_pkg::TIME_W-1:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_region_out  = region_ff;
   assign rsp_depth       = depth_ff;
   assign rsp_start_us    = start_ff;
   assign rsp_duration_us = dur_ff;

   // the result slot is free whenever a pop completes
   a_pop_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == nit_pkg::ST_POP) |-> !rsp_valid_ff)
      else $error("pop completes onto an occupied result slot");

   // open count never passes the stack depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= nit_pkg::CNT_W'(nit_pkg::STACK_DEPTH))
      else $error("open count beyond stack depth");

   // an item taken while disabled leaves the stack alone
   a_disabled_hold: assert property (@(posedge clock) disable iff (reset)
      (accept && !enable_ff) |=> ($stable(count_ff) && (state_ff == nit_pkg::ST_IDLE)))
      else $error("disabled item changed the stack");

   // a successful end shows its OK record after the registered memory read and the ST_POP state
   a_pop_result: assert property (@(posedge clock) disable iff (reset)
      pop_en |=> ##1 (rsp_valid_ff && (status_ff == nit_pkg::STATUS_OK)))
      else $error("pop record missing");

endmodule

// ===== dv/nested_interval_timer_tb.sv =====
// self-checking testbench for the nested interval timer
`timescale 1ns / 1ps

module nested_interval_timer_tb;

   // one record on the result channel
   typedef struct packed {
      nit_pkg::status_type              status;
      logic [nit_pkg::ID_W-1:0]         region;
      logic [nit_pkg::DEPTH_W-1:0]      depth;
      logic [nit_pkg::TIME_W-1:0]       start_us;
      logic [nit_pkg::TIME_W-1:0]       duration_us;
   } region_record_type;

   // tracks the open regions and holds the records still expected, errors included
   class region_tracker;
      logic [nit_pkg::ENTRY_W-1:0]  open_regions [nit_pkg::STACK_DEPTH];
      int unsigned                  open_count;
      bit                           enabled;
      int                           errors;
      region_record_type            pending_records [$];

      function new();
         open_count = 0;
         enabled    = 1'b0;
         errors     = 0;
      endfunction

      function int pending();
         return pending_records.size();
      endfunction

      // append one expected record behind the others
      function void queue_record(input region_record_type rec);
         pending_records = {pending_records, rec};
      endfunction

      task report(input string msg);
         $display("[%0t] mismatch: %s", $realtime, msg);
         errors++;
      endtask

      // update the open regions for one accepted item and queue its record, if it has one
      function void note_item(input logic kind, input logic [nit_pkg::ID_W-1:0] id,
                              input logic [nit_pkg::TIME_W-1:0] now_us);
         region_record_type rec;
         logic [nit_pkg::ENTRY_W-1:0] top;
         if (!enabled) return;
         rec = '0;
         if (kind == nit_pkg::KIND_BEGIN) begin
            if (open_count >= nit_pkg::STACK_DEPTH) begin
               rec.status = nit_pkg::STATUS_OVERFLOW;
               queue_record(rec);
            end else begin
               open_regions[open_count] = {id, now_us};
               open_count++;
            end
         end else if (open_count == 0) begin
            rec.status = nit_pkg::STATUS_UNDERFLOW;
            queue_record(rec);
         end else begin
            open_count--;
            top             = open_regions[open_count];
            rec.status      = nit_pkg::STATUS_OK;
            rec.region      = top[nit_pkg::ENTRY_W-1:nit_pkg::TIME_W];
            rec.depth       = open_count[nit_pkg::DEPTH_W-1:0];
            rec.start_us    = top[nit_pkg::TIME_W-1:0];
            rec.duration_us = now_us - top[nit_pkg::TIME_W-1:0];
            queue_record(rec);
         end
      endfunction

      task check_record(input region_record_type got);
         region_record_type want;
         if (pending_records.size() == 0) begin
            report($sformatf("record with nothing expected, status %0d", got.status));
            return;
         end
         want = pending_records.pop_front();
         if (got.status !== want.status)
            report($sformatf("status %0d, wanted %0d", got.status, want.status));
         if (got.region !== want.region)
            report($sformatf("region %h, wanted %h", got.region, want.region));
         if (got.depth !== want.depth)
            report($sformatf("depth %0d, wanted %0d", got.depth, want.depth));
         if (got.start_us !== want.start_us)
            report($sformatf("start %h, wanted %h", got.start_us, want.start_us));
         if (got.duration_us !== want.duration_us)
            report($sformatf("duration %h, wanted %h", got.duration_us, want.duration_us));
      endtask
   endclass

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic                          req_kind;
   logic [nit_pkg::ID_W-1:0]      req_region_id;
   logic [nit_pkg::TIME_W-1:0]    req_time_us;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [1:0]                    rsp_status;
   logic [nit_pkg::ID_W-1:0]      rsp_region_out;
   logic [nit_pkg::DEPTH_W-1:0]   rsp_depth;
   logic [nit_pkg::TIME_W-1:0]    rsp_start_us;
   logic [nit_pkg::TIME_W-1:0]    rsp_duration_us;
   logic                          csr_we;
   logic                          csr_wdata;

   region_tracker                 tracker = new();
   region_record_type             seen;
   logic [nit_pkg::TIME_W-1:0]    now_us;     // running timestamp for well-formed traffic
   bit                            quiet;      // no idling on either side in the tail
   int                            stall_left;

   nested_interval_timer dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_region_id   (req_region_id),
      .req_time_us     (req_time_us),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_region_out  (rsp_region_out),
      .rsp_depth       (rsp_depth),
      .rsp_start_us    (rsp_start_us),
      .rsp_duration_us (rsp_duration_us),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

   // receiver stalls come in short bursts, none in the tail
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall  = 1'b1;
         stall_left = stall_left - 1;
      end else if (!quiet && !reset && $urandom_range(0, 4) == 0) begin
         rsp_stall  = 1'b1;
         stall_left = $urandom_range(0, 2);
      end else begin
         rsp_stall  = 1'b0;
      end
   end

   // take every record at the edge where it is handed over
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         seen.status      = nit_pkg::status_type'(rsp_status);
         seen.region      = rsp_region_out;
         seen.depth       = rsp_depth;
         seen.start_us    = rsp_start_us;
         seen.duration_us = rsp_duration_us;
         tracker.check_record(seen);
      end
   end

   function automatic logic [nit_pkg::TIME_W-1:0] rand_time();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      return raw[nit_pkg::TIME_W-1:0];
   endfunction

   // mostly a running clock, sometimes anywhere, sometimes just below the wrap
   function automatic logic [nit_pkg::TIME_W-1:0] next_time();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
         now_us = rand_time();
      end else if (pick < 8) begin
         now_us = {nit_pkg::TIME_W{1'b1}} - $urandom_range(0, 500);
      end else begin
         now_us = now_us + $urandom_range(0, 2000);
      end
      return now_us;
   endfunction

   // present one item from a falling edge and hold it until taken
   task automatic send_item(input logic kind, input logic [nit_pkg::ID_W-1:0] id,
                            input logic [nit_pkg::TIME_W-1:0] t);
      req_valid     = 1'b1;
      req_kind      = kind;
      req_region_id = id;
      req_time_us   = t;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      tracker.note_item(kind, id, t);
      @(negedge clock);
   endtask

   // sender gap with req_valid low now and then
   task automatic sender_gap();
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
   endtask

   // wait for every record, then let a pending pop finish
   task automatic wait_idle();
      req_valid = 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_enable(input logic value);
      csr_we    = 1'b1;
      csr_wdata = value;
      @(posedge clock);
      tracker.enabled = value;
      @(negedge clock);
      csr_we    = 1'b0;
   endtask

   // random traffic steered toward a drifting target depth: a target past
   // full drives overflows, a target below empty drives underflows
   task automatic run_phase(input int n_items, input bit last);
      int target;
      int depth;
      logic kind;
      for (int i = 0; i < n_items; i++) begin
         quiet = last && (i >= n_items - 150);
         if (i % 48 == 0) target = $urandom_range(0, nit_pkg::STACK_DEPTH + 2) - 1;
         depth = tracker.open_count;
         if ($urandom_range(0, 19) == 0) begin
            kind = 1'($urandom_range(0, 1));
         end else if (depth < target) begin
            kind = ($urandom_range(0, 9) < 8) ? nit_pkg::KIND_BEGIN : nit_pkg::KIND_END;
         end else if (depth > target) begin
            kind = ($urandom_range(0, 9) < 8) ? nit_pkg::KIND_END : nit_pkg::KIND_BEGIN;
         end else begin
            kind = 1'($urandom_range(0, 1));
         end
         send_item(kind, 16'($urandom_range(0, 16'hFFFF)), next_time());
         sender_gap();
      end
   endtask

   bit phase_enable [6] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
   int phase_items  [6] = '{460, 40, 460, 460, 40, 460};

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_kind      = nit_pkg::KIND_BEGIN;
      req_region_id = '0;
      req_time_us   = '0;
      rsp_stall     = 1'b0;
      csr_we        = 1'b0;
      csr_wdata     = 1'b0;
      quiet         = 1'b0;
      stall_left    = 0;
      now_us        = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // disabled out of reset: these items are dropped
      send_item(nit_pkg::KIND_END, 16'h1234, 48'h10);
      send_item(nit_pkg::KIND_BEGIN, 16'h5678, 48'h20);
      wait_idle();
      write_enable(1'b1);

      // end with nothing open
      send_item(nit_pkg::KIND_END, 16'hFFFF, {nit_pkg::TIME_W{1'b1}});
      // extremes of id and time, including a duration that wraps
      send_item(nit_pkg::KIND_BEGIN, 16'h0000, 48'h0);
      send_item(nit_pkg::KIND_END, 16'hFFFF, {nit_pkg::TIME_W{1'b1}});
      send_item(nit_pkg::KIND_BEGIN, 16'hFFFF, {nit_pkg::TIME_W{1'b1}});
      send_item(nit_pkg::KIND_END, 16'h0000, 48'h0);
      // fill the stack, then one begin too many
      for (int i = 0; i < nit_pkg::STACK_DEPTH; i++) begin
         send_item(nit_pkg::KIND_BEGIN, (i % 2) ? 16'hFFFF : 16'(i),
                   (i % 2) ? {nit_pkg::TIME_W{1'b1}} - i : 48'(i));
      end
      send_item(nit_pkg::KIND_BEGIN, 16'hA5A5, 48'h5A5A_5A5A_5A5A);
      for (int i = 0; i < 3; i++) send_item(nit_pkg::KIND_END, 16'h0, rand_time());

      // random phases, regions left open carry across disabled stretches
      for (int p = 0; p < 6; p++) begin
         wait_idle();
         write_enable(phase_enable[p]);
         run_phase(phase_items[p], p == 5);
      end

      wait_idle();
      repeat (8) @(negedge clock);
      if (tracker.pending() != 0) tracker.report("records still expected at the end");
      if (tracker.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/nit_pkg.sv
hw/rtl/nested_interval_timer.sv
dv/nested_interval_timer_tb.sv
